// ===== design/bpu_pkg.sv =====
// Shared types and constants for the bitfield pixel unpacker.
// Used by the register block, the channel lanes and the top level.
package bpu_pkg;

	localparam int NumLanes = 4;
	localparam int WordW    = 32;
	// The dividend is field * 255, so it needs eight more bits than the field.
	localparam int DvdW     = WordW + 8;
	localparam int DivSteps = DvdW;

	localparam logic [2:0] RegRedMask   = 3'd0;
	localparam logic [2:0] RegGreenMask = 3'd1;
	localparam logic [2:0] RegBlueMask  = 3'd2;
	localparam logic [2:0] RegAlphaMask = 3'd3;
	localparam logic [2:0] RegMode      = 3'd4;

	localparam logic ModeSwap     = 1'b0;
	localparam logic ModeBitfield = 1'b1;

	typedef struct packed {
		logic [WordW-1:0] mask_r;
		logic [WordW-1:0] mask_g;
		logic [WordW-1:0] mask_b;
		logic [WordW-1:0] mask_a;
		logic             decode_mode;
	} cfg_t;

	typedef struct packed {
		logic       done;
		logic [7:0] value;
	} lane_res_t;

	// Index of the lowest set bit; zero for an empty mask.
	function automatic logic [4:0] low_zeros(input logic [WordW-1:0] m);
		logic [4:0] n;
		n = '0;
		for (int i = WordW - 1; i >= 0; i--) begin
			if (m[i]) n = 5'(i);
		end
		return n;
	endfunction

	function automatic logic [5:0] ones_in(input logic [WordW-1:0] m);
		logic [5:0] n;
		n = '0;
		for (int i = 0; i < WordW; i++) begin
			n = n + 6'(m[i]);
		end
		return n;
	endfunction

endpackage

// ===== design/bpu_regs.sv =====
// Configuration register block with an APB-style write and read port.
// Depends on bpu_pkg for the register indexes and the configuration struct.
module bpu_regs (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [4:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	output bpu_pkg::cfg_t    cfg
);
	import bpu_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr     = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr) begin
			unique case (idx)
				RegRedMask:   cfg_q.mask_r      <= pwdata;
				RegGreenMask: cfg_q.mask_g      <= pwdata;
				RegBlueMask:  cfg_q.mask_b      <= pwdata;
				RegAlphaMask: cfg_q.mask_a      <= pwdata;
				RegMode:      cfg_q.decode_mode <= pwdata[0];
				default:      ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			RegRedMask:   prdata = cfg_q.mask_r;
			RegGreenMask: prdata = cfg_q.mask_g;
			RegBlueMask:  prdata = cfg_q.mask_b;
			RegAlphaMask: prdata = cfg_q.mask_a;
			RegMode:      prdata = {31'd0, cfg_q.decode_mode};
			default:      prdata = '0;
		endcase
	end

endmodule

// ===== design/bpu_lane.sv =====
// One channel lane: extracts a mask-selected field and rescales it to 8 bits
// with a bit-serial restoring divider. Depends on bpu_pkg.
module bpu_lane (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic                    take,
	input  logic [31:0]             word,
	input  logic [31:0]             mask,
	output bpu_pkg::lane_res_t      res
);
	import bpu_pkg::*;

	localparam logic [1:0] StIdle = 2'd0;
	localparam logic [1:0] StLoad = 2'd1;
	localparam logic [1:0] StDiv  = 2'd2;
	localparam logic [1:0] StDone = 2'd3;

	logic [1:0]       state_q;
	logic [5:0]       cnt_q;
	logic [WordW-1:0] fld_q;
	logic [DvdW-1:0]  dvd_q;
	logic [WordW-1:0] dsr_q;
	logic [WordW-1:0] rem_q;
	logic [7:0]       quo_q;
	logic [7:0]       low_q;
	logic             zero_q;
	logic             pop8_q;

	logic [4:0]       tz;
	logic [5:0]       pop;
	logic [WordW-1:0] v;
	logic [DvdW-1:0]  x;
	logic [WordW-1:0] d;
	logic [WordW:0]   trial;
	logic             ge;
	logic [WordW:0]   diff;

	always_comb begin
		tz    = low_zeros(mask);
		pop   = ones_in(mask);
		v     = fld_q >> tz;
		x     = {v, 8'd0} - {8'd0, v};
		d     = WordW'((33'd1 << pop) - 33'd1);
		trial = {rem_q, dvd_q[DvdW-1]};
		ge    = trial >= {1'b0, dsr_q};
		diff  = trial - {1'b0, dsr_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= StIdle;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				StIdle: if (start) state_q <= StLoad;
				StLoad: begin
					state_q <= StDiv;
					cnt_q   <= '0;
				end
				StDiv: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'(DivSteps - 1)) state_q <= StDone;
				end
				StDone: if (take) state_q <= StIdle;
				default: state_q <= StIdle;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == StIdle && start) begin
			fld_q <= word & mask;
		end
		if (state_q == StLoad) begin
			dvd_q  <= x;
			dsr_q  <= d;
			rem_q  <= '0;
			quo_q  <= '0;
			low_q  <= v[7:0];
			zero_q <= (mask == '0);
			pop8_q <= (pop == 6'd8);
		end
		if (state_q == StDiv) begin
			dvd_q <= {dvd_q[DvdW-2:0], 1'b0};
			rem_q <= ge ? diff[WordW-1:0] : trial[WordW-1:0];
			quo_q <= {quo_q[6:0], ge};
		end
	end

	// An eight-bit field needs no rescale; an empty mask reads zero.
	assign res.done  = (state_q == StDone);
	assign res.value = zero_q ? 8'd0 : (pop8_q ? low_q : quo_q);

endmodule

// ===== design/bitfield_pixel_unpacker.sv =====
// A pixel runs through each lane's load state and divider, then the output register.
// A new pixel is not taken until all lanes finish the 40-step divide of the last one.
// The next pixel is taken while a finished result still waits in the output register.
// Reset (arst_n low, asynchronous) clears the configuration registers to zero, the
// alpha flag and all handshake state; the data registers are not reset.
// Top level: four channel lanes, the swap path and the output merge stage.
module bitfield_pixel_unpacker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] pixel_word
	input  logic        s_tuser,  // [0] frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata   // [7:0] out_byte0, [15:8] out_byte1, [23:16] out_byte2,
	                              // [31:24] out_byte3, [32] alpha_seen, [39:33] zero
);
	import bpu_pkg::*;

	cfg_t       cfg;
	lane_res_t  lane_res [NumLanes];
	logic [31:0] lane_mask [NumLanes];
	logic       busy_q;
	logic       fs_q;
	logic [31:0] word_q;
	logic       flag_q;
	logic       out_valid_q;
	logic [39:0] out_data_q;
	logic       accept;
	logic       all_done;
	logic       take;
	logic       flag_n;
	logic [31:0] bytes;

	bpu_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign lane_mask[0] = cfg.mask_r;
	assign lane_mask[1] = cfg.mask_g;
	assign lane_mask[2] = cfg.mask_b;
	assign lane_mask[3] = cfg.mask_a;

	assign s_tready = !busy_q;
	assign accept   = s_tvalid & s_tready;

	for (genvar g = 0; g < NumLanes; g++) begin : g_lane
		bpu_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (accept),
			.take   (take),
			.word   (s_tdata),
			.mask   (lane_mask[g]),
			.res    (lane_res[g])
		);
	end

	always_comb begin
		all_done = busy_q;
		for (int i = 0; i < NumLanes; i++) begin
			all_done = all_done & lane_res[i].done;
		end
		take = all_done & (!out_valid_q | m_tready);

		if (cfg.decode_mode == ModeBitfield) begin
			bytes = {lane_res[3].value, lane_res[2].value, lane_res[1].value,
				lane_res[0].value};
		end else begin
			bytes = {word_q[31:24], word_q[7:0], word_q[15:8], word_q[23:16]};
		end

		// A frame start clears the flag before this pixel's alpha is looked at.
		flag_n = (fs_q ? 1'b0 : flag_q)
			| ((cfg.decode_mode == ModeBitfield) && (lane_res[3].value != 8'd0));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			flag_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (take) begin
				busy_q <= 1'b0;
			end
			if (take) begin
				flag_q      <= flag_n;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_q <= s_tdata;
			fs_q   <= s_tuser;
		end
		if (take) begin
			out_data_q <= {7'd0, flag_n, bytes};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

// ===== design/bpu_checker.sv =====
// Port-level checks for the bitfield pixel unpacker and the bind that attaches them.
// Sees only the top-level stream ports; no package needed.
module bpu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second pixel taken while one is in the lanes");

	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
		else $error("result appeared right after a request");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:33] == 7'd0)
		else $error("padding bits of the result are not zero");

endmodule

bind bitfield_pixel_unpacker bpu_checker u_bpu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
